>>> sv/x86enc_pkg.sv
// Shared types and constants for the x86-64 instruction byte encoder.
package x86enc_pkg;

    // header byte slots, emitted lowest index first
    localparam int HDR_W = 9;
    localparam logic [3:0] HDR_FS    = 4'd0;
    localparam logic [3:0] HDR_GS    = 4'd1;
    localparam logic [3:0] HDR_OPSZ  = 4'd2;
    localparam logic [3:0] HDR_ADSZ  = 4'd3;
    localparam logic [3:0] HDR_REX   = 4'd4;
    localparam logic [3:0] HDR_ESC   = 4'd5;
    localparam logic [3:0] HDR_OPC   = 4'd6;
    localparam logic [3:0] HDR_MODRM = 4'd7;
    localparam logic [3:0] HDR_SIB   = 4'd8;

    localparam logic [7:0] BYTE_FS   = 8'h64;
    localparam logic [7:0] BYTE_GS   = 8'h65;
    localparam logic [7:0] BYTE_OPSZ = 8'h66;
    localparam logic [7:0] BYTE_ADSZ = 8'h67;
    localparam logic [7:0] BYTE_REX  = 8'h40;
    localparam logic [7:0] BYTE_ESC  = 8'h0F;

    typedef struct packed {
        logic load;
        logic shift;
    } le_ctl_t;

    // byte count of a displacement or immediate size code; codes four and above all give eight bytes
    function automatic logic [3:0] field_bytes(input logic [2:0] code);
        logic [3:0] n;
        unique case (code)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd1;
            3'd2:    n = 4'd2;
            3'd3:    n = 4'd4;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

>>> sv/x86enc_le_shift.sv
// Little-endian byte shift register for a displacement or immediate field.
module x86enc_le_shift
    import x86enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  le_ctl_t     ctl,
    input  logic [63:0] load_value,
    input  logic [2:0]  load_size,
    output logic [7:0]  byte_out,
    output logic [3:0]  cnt_out
);

    logic [63:0] data_reg, data_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (ctl.load) begin
            data_next = load_value;
            cnt_next  = field_bytes(load_size);
        end else if (ctl.shift) begin
            data_next = {8'h00, data_reg[63:8]};
            cnt_next  = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign byte_out = data_reg[7:0];
    assign cnt_out  = cnt_reg;

    shift_only_when_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift && !ctl.load |-> cnt_reg != 4'd0)
        else $error("field shifted with no bytes left");

    load_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> cnt_reg <= 4'd8)
        else $error("field byte count out of range");

    shift_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift && !ctl.load |=> cnt_reg == $past(cnt_reg) - 4'd1)
        else $error("field byte count did not step down");

endmodule

>>> sv/x86_64_instruction_encoder_top.sv
// Top level: x86-64 instruction encoder, one machine-code byte per output transfer.
// The input transfer loads hdr_reg and the field registers; each byte is then registered into m_out_byte.
// Output: one byte per cycle while m_ready stays high, 1 to 25 bytes per instruction.
// The input is not ready again until the byte sequencer has issued the last byte of the instruction.
// Displacement and immediate: 64-bit shift registers, one byte a cycle unless stalled.
// Reset (aresetn low, synchronous) clears the sequencer and output valid; no data is kept.
module x86_64_instruction_encoder_top
    import x86enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_prefix_flags,
    input  logic [7:0]  s_opcode_byte,
    input  logic        s_modrm_present,
    input  logic [1:0]  s_mod_field,
    input  logic [2:0]  s_reg_field,
    input  logic [2:0]  s_rm_field,
    input  logic        s_sib_present,
    input  logic [7:0]  s_sib_fields,
    input  logic [2:0]  s_disp_size,
    input  logic [63:0] s_displacement,
    input  logic [2:0]  s_imm_size,
    input  logic [63:0] s_immediate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte
);

    logic [HDR_W-1:0] hdr_reg, hdr_next;
    logic [7:0]       rex_reg, opc_reg, modrm_reg, sib_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_out_byte_reg, m_out_byte_next;
    logic             m_last_byte_reg, m_last_byte_next;

    le_ctl_t          disp_ctl, imm_ctl;
    logic [7:0]       disp_byte, imm_byte;
    logic [3:0]       disp_cnt, imm_cnt;

    logic             busy, accept, gen;
    logic [3:0]       sel;
    logic [HDR_W-1:0] hdr_rest;
    logic [7:0]       hdr_byte;

    assign busy    = (hdr_reg != '0) || (disp_cnt != 4'd0) || (imm_cnt != 4'd0);
    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign gen     = busy && (!m_valid_reg || m_ready);

    // lowest pending header slot goes out first
    always_comb begin
        sel = HDR_OPC;
        for (int i = HDR_W - 1; i >= 0; i--) begin
            if (hdr_reg[i]) begin
                sel = 4'(i);
            end
        end
    end

    assign hdr_rest = hdr_reg & ~(HDR_W'(1) << sel);

    always_comb begin
        unique case (sel)
            HDR_FS:    hdr_byte = BYTE_FS;
            HDR_GS:    hdr_byte = BYTE_GS;
            HDR_OPSZ:  hdr_byte = BYTE_OPSZ;
            HDR_ADSZ:  hdr_byte = BYTE_ADSZ;
            HDR_REX:   hdr_byte = rex_reg;
            HDR_ESC:   hdr_byte = BYTE_ESC;
            HDR_OPC:   hdr_byte = opc_reg;
            HDR_MODRM: hdr_byte = modrm_reg;
            HDR_SIB:   hdr_byte = sib_reg;
            default:   hdr_byte = opc_reg;
        endcase
    end

    always_comb begin
        hdr_next         = hdr_reg;
        m_valid_next     = m_valid_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_last_byte_next = m_last_byte_reg;
        disp_ctl         = '{load: accept, shift: 1'b0};
        imm_ctl          = '{load: accept, shift: 1'b0};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            hdr_next = {s_sib_present, s_modrm_present, 1'b1, s_prefix_flags[9],
                        |s_prefix_flags[8:4], s_prefix_flags[3:0]};
        end else if (gen) begin
            m_valid_next = 1'b1;
            priority if (hdr_reg != '0) begin
                hdr_next         = hdr_rest;
                m_out_byte_next  = hdr_byte;
                m_last_byte_next = (hdr_rest == '0) && (disp_cnt == 4'd0)
                                   && (imm_cnt == 4'd0);
            end else if (disp_cnt != 4'd0) begin
                disp_ctl.shift   = 1'b1;
                m_out_byte_next  = disp_byte;
                m_last_byte_next = (disp_cnt == 4'd1) && (imm_cnt == 4'd0);
            end else begin
                imm_ctl.shift    = 1'b1;
                m_out_byte_next  = imm_byte;
                m_last_byte_next = (imm_cnt == 4'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hdr_reg     <= hdr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_out_byte_reg  <= m_out_byte_next;
        m_last_byte_reg <= m_last_byte_next;
        if (accept) begin
            rex_reg   <= BYTE_REX | {4'h0, s_prefix_flags[7:4]};
            opc_reg   <= s_opcode_byte;
            modrm_reg <= {s_mod_field, s_reg_field, s_rm_field};
            sib_reg   <= s_sib_fields;
        end
    end

    x86enc_le_shift u_disp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (disp_ctl),
        .load_value (s_displacement),
        .load_size  (s_disp_size),
        .byte_out   (disp_byte),
        .cnt_out    (disp_cnt)
    );

    x86enc_le_shift u_imm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (imm_ctl),
        .load_value (s_immediate),
        .load_size  (s_imm_size),
        .byte_out   (imm_byte),
        .cnt_out    (imm_cnt)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_last_byte = m_last_byte_reg;

    opcode_queued_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> hdr_reg[HDR_OPC])
        else $error("opcode slot not pending after input transfer");

    last_byte_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        gen && m_last_byte_next |=> !busy)
        else $error("sequencer still busy after last byte");

    busy_starts_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy) |-> $past(accept))
        else $error("sequencer started without an input transfer");

    no_gen_over_held_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(m_out_byte_reg) && $stable(m_last_byte_reg))
        else $error("held output byte overwritten");

endmodule

>>> sim/x86_64_instruction_encoder_top_tb.sv
// Self-checking testbench for the x86-64 instruction encoder: directed and random instructions.
module x86_64_instruction_encoder_top_tb
    import x86enc_pkg::*;
();

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 230;

    typedef struct {
        logic [9:0]  prefix_flags;
        logic [7:0]  opcode_byte;
        logic        modrm_present;
        logic [1:0]  mod_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic        sib_present;
        logic [7:0]  sib_fields;
        logic [2:0]  disp_size;
        logic [63:0] displacement;
        logic [2:0]  imm_size;
        logic [63:0] immediate;
    } instr_t;

    // Holds the machine-code bytes still owed by the encoder, each as {last, byte}.
    class enc_scoreboard;
        logic [8:0] expected_bytes[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int field_len(logic [2:0] code);
            case (code)
                3'd0:    return 0;
                3'd1:    return 1;
                3'd2:    return 2;
                3'd3:    return 4;
                default: return 8;  // codes 4..7 all mean eight bytes
            endcase
        endfunction

        function void note_instruction(instr_t ins);
            logic [7:0] seq[$];
            logic [7:0] rex;
            int         k;
            if (ins.prefix_flags[0]) seq.push_back(BYTE_FS);
            if (ins.prefix_flags[1]) seq.push_back(BYTE_GS);
            if (ins.prefix_flags[2]) seq.push_back(BYTE_OPSZ);
            if (ins.prefix_flags[3]) seq.push_back(BYTE_ADSZ);
            if (|ins.prefix_flags[8:4]) begin
                rex = BYTE_REX | {4'b0000, ins.prefix_flags[7:4]};
                seq.push_back(rex);
            end
            if (ins.prefix_flags[9]) seq.push_back(BYTE_ESC);
            seq.push_back(ins.opcode_byte);
            if (ins.modrm_present)
                seq.push_back({ins.mod_field, ins.reg_field, ins.rm_field});
            if (ins.sib_present) seq.push_back(ins.sib_fields);
            for (k = 0; k < field_len(ins.disp_size); k++)
                seq.push_back(ins.displacement[8*k +: 8]);
            for (k = 0; k < field_len(ins.imm_size); k++)
                seq.push_back(ins.immediate[8*k +: 8]);
            for (k = 0; k < seq.size(); k++)
                expected_bytes.push_back({k == seq.size() - 1, seq[k]});
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_byte(logic [7:0] got_byte, logic got_last);
            logic [8:0] want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h last %0b with nothing pending",
                                          got_byte, got_last));
                return;
            end
            want = expected_bytes.pop_front();
            if (got_byte !== want[7:0])
                report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, want[7:0]));
            if (got_last !== want[8])
                report_mismatch($sformatf("last_byte %0b, want %0b", got_last, want[8]));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [9:0]  s_prefix_flags;
    logic [7:0]  s_opcode_byte;
    logic        s_modrm_present;
    logic [1:0]  s_mod_field;
    logic [2:0]  s_reg_field;
    logic [2:0]  s_rm_field;
    logic        s_sib_present;
    logic [7:0]  s_sib_fields;
    logic [2:0]  s_disp_size;
    logic [63:0] s_displacement;
    logic [2:0]  s_imm_size;
    logic [63:0] s_immediate;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last_byte;

    enc_scoreboard sb = new();
    bit            steady = 0;        // no idling on either side while set
    bit            hold_results = 0;  // receiver holds off for a long stretch
    int            idle_cycles = 0;

    x86_64_instruction_encoder_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_prefix_flags  (s_prefix_flags),
        .s_opcode_byte   (s_opcode_byte),
        .s_modrm_present (s_modrm_present),
        .s_mod_field     (s_mod_field),
        .s_reg_field     (s_reg_field),
        .s_rm_field      (s_rm_field),
        .s_sib_present   (s_sib_present),
        .s_sib_fields    (s_sib_fields),
        .s_disp_size     (s_disp_size),
        .s_displacement  (s_displacement),
        .s_imm_size      (s_imm_size),
        .s_immediate     (s_immediate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_byte     (m_last_byte)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic instr_t blank_instr(logic [9:0] pf, logic [7:0] opc);
        instr_t t;
        t.prefix_flags  = pf;
        t.opcode_byte   = opc;
        t.modrm_present = 0;
        t.mod_field     = 0;
        t.reg_field     = 0;
        t.rm_field      = 0;
        t.sib_present   = 0;
        t.sib_fields    = 0;
        t.disp_size     = 0;
        t.displacement  = 0;
        t.imm_size      = 0;
        t.immediate     = 0;
        return t;
    endfunction

    function automatic instr_t rand_instr();
        instr_t t;
        t.prefix_flags  = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom);
        t.opcode_byte   = 8'($urandom);
        t.modrm_present = ($urandom_range(0, 3) != 0);
        t.mod_field     = 2'($urandom);
        t.reg_field     = 3'($urandom);
        t.rm_field      = 3'($urandom);
        t.sib_present   = 1'($urandom_range(0, 1));
        t.sib_fields    = 8'($urandom);
        t.disp_size     = 3'($urandom);
        t.displacement  = {$urandom, $urandom};
        t.imm_size      = 3'($urandom);
        t.immediate     = {$urandom, $urandom};
        return t;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task send_instruction(instr_t ins, bit no_gap);
        int gap;
        gap = (no_gap || steady) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_prefix_flags  = ins.prefix_flags;
        s_opcode_byte   = ins.opcode_byte;
        s_modrm_present = ins.modrm_present;
        s_mod_field     = ins.mod_field;
        s_reg_field     = ins.reg_field;
        s_rm_field      = ins.rm_field;
        s_sib_present   = ins.sib_present;
        s_sib_fields    = ins.sib_fields;
        s_disp_size     = ins.disp_size;
        s_displacement  = ins.displacement;
        s_imm_size      = ins.imm_size;
        s_immediate     = ins.immediate;
        s_valid         = 1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_instruction(ins);
        @(negedge aclk);
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task send_directed();
        instr_t t;
        send_instruction(blank_instr(10'h000, 8'h90), 0);
        // longest form: every prefix, ModRM, SIB, eight-byte displacement and immediate
        t = blank_instr(10'h3FF, 8'hFF);
        t.modrm_present = 1; t.mod_field = 3; t.reg_field = 7; t.rm_field = 7;
        t.sib_present = 1; t.sib_fields = 8'hFF;
        t.disp_size = 4; t.displacement = '1;
        t.imm_size = 4; t.immediate = '1;
        send_instruction(t, 0);
        send_instruction(blank_instr(10'h100, 8'h50), 0);  // bare REX alone
        send_instruction(blank_instr(10'h080, 8'h01), 0);
        send_instruction(blank_instr(10'h040, 8'h02), 0);
        send_instruction(blank_instr(10'h020, 8'h03), 0);
        send_instruction(blank_instr(10'h010, 8'h04), 0);
        send_instruction(blank_instr(10'h00F, 8'h00), 0);
        send_instruction(blank_instr(10'h200, 8'hAF), 0);
        t = blank_instr(10'h000, 8'h8D);  // SIB with no ModRM
        t.sib_present = 1; t.sib_fields = 8'h24;
        send_instruction(t, 0);
        t = blank_instr(10'h000, 8'h00);
        t.modrm_present = 1;
        send_instruction(t, 0);
        for (int sz = 1; sz <= 7; sz++) begin
            t = blank_instr(10'h000, 8'h8B);
            t.modrm_present = 1; t.mod_field = 2; t.reg_field = 3'(sz); t.rm_field = 5;
            t.disp_size = 3'(sz);
            case (sz % 3)
                0:       t.displacement = 64'h8000_0000_0000_0000;
                1:       t.displacement = 64'h7FFF_FFFF_FFFF_FFFF;
                default: t.displacement = 64'h0123_4567_89AB_CDEF;
            endcase
            send_instruction(t, 0);
        end
        for (int sz = 1; sz <= 7; sz++) begin
            t = blank_instr(10'h080, 8'hB8);
            t.imm_size = 3'(sz);
            t.immediate = (sz % 2) ? 64'hFEDC_BA98_7654_3210 : 64'h8000_0000_0000_0001;
            send_instruction(t, 0);
        end
    endtask

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        int off;
        m_ready = 0;
        off = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready = 0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_results = 0;
            end else if (steady) begin
                m_ready = 1;
            end else if (off > 0) begin
                m_ready = 0;
                off--;
            end else begin
                m_ready = 1;
                if ($urandom_range(0, 9) < 3) off = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_byte(m_out_byte, m_last_byte);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 0;
        s_valid = 0;
        void'(blank_instr(10'h000, 8'h00));
        {s_prefix_flags, s_opcode_byte, s_modrm_present, s_mod_field, s_reg_field} = '0;
        {s_rm_field, s_sib_present, s_sib_fields, s_disp_size, s_displacement} = '0;
        {s_imm_size, s_immediate} = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1;

        send_directed();
        s_valid = 0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            send_instruction(rand_instr(), 0);

        // back up the byte stream so the encoder stalls its input
        hold_results = 1;
        for (int i = 0; i < 12; i++)
            send_instruction(rand_instr(), 1);

        s_valid = 0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2; i++) begin
            steady = (i >= 20 && i < 50);
            send_instruction(rand_instr(), 0);
        end
        steady = 0;
        s_valid = 0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
